// ===== rtl/core/rrts_pkg.sv =====
`default_nettype none

package rrts_pkg;

  // table size and derived widths
  localparam int NUM_SLOTS = 4;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

  localparam int FUNC_W   = 2;
  localparam int ADDR_W   = 64;
  localparam int STATUS_W = 2;
  localparam int SLOT_F_W = 2;

  // operation codes; code 3 carries no operation and gets an OK result for the current slot
  typedef enum logic [FUNC_W-1:0] {
    FUNC_CREATE = 2'd0,
    FUNC_YIELD  = 2'd1,
    FUNC_EXIT   = 2'd2
  } func_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_NOREADY = 2'd2
  } status_e;

  // per-slot state
  typedef enum logic [1:0] {
    SLOT_UNUSED  = 2'd0,
    SLOT_RUNNING = 2'd1,
    SLOT_READY   = 2'd2
  } slot_state_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CREATE,
    S_YIELD,
    S_READ,
    S_RESP
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_step;
    logic create_hit;
    logic create_full;
    logic yield_hit;
    logic yield_none;
    logic load_out;
  } rrts_cmd_t;

  // datapath to controller
  typedef struct packed {
    func_e in_func;
    logic  hit;
    logic  last;
    logic  out_free;
  } rrts_stat_t;

  // low bits of a slot index as carried in the result field
  function automatic logic [SLOT_F_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+SLOT_F_W-1:0] ext;
    ext = {{SLOT_F_W{1'b0}}, idx};
    return ext[SLOT_F_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rrts_in_if.sv =====
`default_nettype none

interface rrts_in_if;
  import rrts_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [ADDR_W-1:0]   entry_addr;
  logic [ADDR_W-1:0]   resume_addr;

  modport source (output valid, output func, output entry_addr, output resume_addr,
                  input ready);
  modport sink   (input valid, input func, input entry_addr, input resume_addr,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rrts_out_if.sv =====
`default_nettype none

interface rrts_out_if;
  import rrts_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_F_W-1:0] slot;
  logic [ADDR_W-1:0]   next_addr;
  logic                released;

  modport source (output valid, output status, output slot, output next_addr,
                  output released, input ready);
  modport sink   (input valid, input status, input slot, input next_addr,
                  input released, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/round_robin_thread_slot_scheduler.sv =====
// Flow: create scans the state table from slot 0 until an unused slot is found; yield or exit
//   scan from the current slot until a ready slot is found, with a registered memory read on a hit.
// Throughput: one item in flight; the next is accepted the cycle after the result is
//   registered, so the time an item takes is set by the one-slot-per-cycle scan of the state
//   table, the registered resume-memory read and any back-pressure on the result.
// Reset: asynchronous, active low; slot 0 running, all others unused, current slot 0.
`default_nettype none

module round_robin_thread_slot_scheduler
  import rrts_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  rrts_in_if.sink     in_i,
  rrts_out_if.source  out_o
);

  rrts_cmd_t  cmd;
  rrts_stat_t stat;
  logic       in_ready;

  assign in_i.ready = in_ready;

  rrts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rrts_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .func_i        (in_i.func),
    .entry_addr_i  (in_i.entry_addr),
    .resume_addr_i (in_i.resume_addr),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .status_o      (out_o.status),
    .slot_o        (out_o.slot),
    .next_addr_o   (out_o.next_addr),
    .released_o    (out_o.released),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule

`default_nettype wire

// ===== rtl/core/rrts_ctrl.sv =====
`default_nettype none

module rrts_ctrl
  import rrts_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  rrts_stat_t stat_i,
  output rrts_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (stat_i.in_func)
            FUNC_CREATE: state_d = S_CREATE;
            FUNC_YIELD:  state_d = S_YIELD;
            FUNC_EXIT:   state_d = S_YIELD;
            default:     state_d = S_RESP;
          endcase
        end
      end
      S_CREATE: begin
        if (stat_i.hit || stat_i.last) state_d = S_RESP;
      end
      S_YIELD: begin
        if (stat_i.hit) begin
          state_d = S_READ;
        end else if (stat_i.last) begin
          state_d = S_RESP;
        end
      end
      S_READ: state_d = S_RESP;
      S_RESP: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      S_CREATE: begin
        if (stat_i.hit) begin
          cmd_o.create_hit = 1'b1;
        end else if (stat_i.last) begin
          cmd_o.create_full = 1'b1;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_YIELD: begin
        if (stat_i.hit) begin
          cmd_o.yield_hit = 1'b1;
        end else if (stat_i.last) begin
          cmd_o.yield_none = 1'b1;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_READ: ;
      S_RESP: cmd_o.load_out = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/rrts_dp.sv =====
`default_nettype none

module rrts_dp
  import rrts_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire  [FUNC_W-1:0]   func_i,
  input  wire  [ADDR_W-1:0]   entry_addr_i,
  input  wire  [ADDR_W-1:0]   resume_addr_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_F_W-1:0] slot_o,
  output logic [ADDR_W-1:0]   next_addr_o,
  output logic                released_o,
  input  rrts_cmd_t           cmd_i,
  output rrts_stat_t          stat_o
);

  // slot state table and current slot
  slot_state_e       st_q [NUM_SLOTS];
  slot_state_e       st_d [NUM_SLOTS];
  logic [SLOT_W-1:0] cur_q;

  // operation latched at accept
  func_e             func_q;
  logic [ADDR_W-1:0] entry_q;
  logic [ADDR_W-1:0] resume_q;
  logic [SLOT_W-1:0] idx_q;
  logic [SLOT_W-1:0] idx_nxt;

  // resume address memory
  logic [ADDR_W-1:0] mem [NUM_SLOTS];
  logic [ADDR_W-1:0] rd_q;

  // staged result
  status_e           res_status_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic              res_mem_q;
  logic              res_rel_q;

  func_e in_func;
  logic  out_valid_q;
  logic  out_free;

  assign in_func  = func_e'(func_i);
  assign out_free = !out_valid_q || out_ready_i;

  // round-robin successor of the scan index
  assign idx_nxt = (idx_q == SLOT_LAST) ? '0 : idx_q + SLOT_W'(1);

  // scan status back to the controller
  always_comb begin
    stat_o.in_func  = in_func;
    stat_o.out_free = out_free;
    if (func_q == FUNC_CREATE) begin
      stat_o.hit  = (st_q[idx_q] == SLOT_UNUSED);
      stat_o.last = (idx_q == SLOT_LAST);
    end else begin
      stat_o.hit  = (st_q[idx_q] == SLOT_READY);
      stat_o.last = (idx_nxt == cur_q);
    end
  end

  // slot table update
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) st_d[i] = st_q[i];
    if (cmd_i.accept && in_func == FUNC_EXIT && cur_q != '0) begin
      st_d[cur_q] = SLOT_UNUSED;
    end
    if (cmd_i.create_hit) begin
      st_d[idx_q] = SLOT_READY;
    end
    if (cmd_i.yield_hit) begin
      if (st_q[cur_q] != SLOT_UNUSED) st_d[cur_q] = SLOT_READY;
      st_d[idx_q] = SLOT_RUNNING;
    end
  end

  // control state: table and current slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        st_q[i] <= (i == 0) ? SLOT_RUNNING : SLOT_UNUSED;
      end
      cur_q <= '0;
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++) st_q[i] <= st_d[i];
      if (cmd_i.yield_hit) cur_q <= idx_q;
    end
  end

  // latched operands, scan index and staged result
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q       <= in_func;
      entry_q      <= entry_addr_i;
      resume_q     <= resume_addr_i;
      idx_q        <= (in_func == FUNC_CREATE) ? '0 : cur_q;
      res_status_q <= STATUS_OK;
      res_slot_q   <= cur_q;
      res_mem_q    <= 1'b0;
      res_rel_q    <= 1'b0;
    end
    if (cmd_i.scan_step) idx_q <= idx_nxt;
    if (cmd_i.create_hit) begin
      res_status_q <= STATUS_OK;
      res_slot_q   <= idx_q;
    end
    if (cmd_i.create_full) begin
      res_status_q <= STATUS_FULL;
      res_slot_q   <= '0;
    end
    if (cmd_i.yield_hit) begin
      res_status_q <= STATUS_OK;
      res_slot_q   <= idx_q;
      res_mem_q    <= 1'b1;
      res_rel_q    <= (st_q[cur_q] == SLOT_UNUSED);
    end
    if (cmd_i.yield_none) begin
      res_status_q <= STATUS_NOREADY;
      res_slot_q   <= cur_q;
    end
  end

  // memory: one write port, registered read at the current slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.create_hit) begin
      mem[idx_q] <= entry_q;
    end else if (cmd_i.yield_hit) begin
      mem[cur_q] <= resume_q;
    end
    rd_q <= mem[cur_q];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_o    <= res_status_q;
      slot_o      <= slot_field(res_slot_q);
      next_addr_o <= res_mem_q ? rd_q : '0;
      released_o  <= res_rel_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  // slot 0 is never retired
  a_slot0_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q[0] != SLOT_UNUSED)
    else $error("slot 0 became unused");

  // a switch leaves the new current slot running
  a_switch_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.yield_hit |=> st_q[cur_q] == SLOT_RUNNING)
    else $error("switched-to slot not running");

  // a failed scan never skipped a ready current slot
  a_none_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.yield_none |-> st_q[cur_q] != SLOT_READY)
    else $error("scan missed a ready current slot");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import rrts_pkg::*;

  // code 3 carries no operation
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

  localparam int RAND_ITEMS = 1350;
  localparam int TAIL_ITEMS = 120;
  localparam int MAX_SHOWN  = 10;
  localparam logic [ADDR_W-1:0] ADDR_ONES = '1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] entry_addr;
    logic [ADDR_W-1:0] resume_addr;
  } sched_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_F_W-1:0] slot;
    logic [ADDR_W-1:0]   next_addr;
    logic                released;
  } sched_rsp_t;

  logic clk_i;
  logic rst_ni;

  rrts_in_if  in_if ();
  rrts_out_if out_if ();

  round_robin_thread_slot_scheduler u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // shadow of the slot table
  slot_state_e       slot_st [NUM_SLOTS];
  logic [ADDR_W-1:0] slot_addr [NUM_SLOTS];
  int                cur_slot;

  sched_req_t req_q [$];
  sched_rsp_t rsp_q [$];
  sched_req_t drv_req;
  int         req_total;
  int         req_taken;
  int         gap_cnt;
  int         stall_cnt;
  int         err_cnt;

  // round-robin scan from the current slot; saves the outgoing address on a switch
  function automatic sched_rsp_t switch_slot(input logic [ADDR_W-1:0] resume);
    sched_rsp_t rsp;
    int         cur;
    int         nxt;
    int         idx;
    bit         found;
    bit         retired;
    rsp   = '0;
    cur   = cur_slot % NUM_SLOTS;
    nxt   = cur;
    found = 1'b0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      idx = (cur + k) % NUM_SLOTS;
      if (!found && slot_st[idx] == SLOT_READY) begin
        nxt   = idx;
        found = 1'b1;
      end
    end
    if (!found) begin
      rsp.status = STATUS_NOREADY;
      rsp.slot   = SLOT_F_W'(cur);
    end else begin
      retired = (slot_st[cur] == SLOT_UNUSED);
      if (!retired) slot_st[cur] = SLOT_READY;
      slot_st[nxt]   = SLOT_RUNNING;
      slot_addr[cur] = resume;
      cur_slot       = nxt;
      rsp.status     = STATUS_OK;
      rsp.slot       = SLOT_F_W'(nxt);
      rsp.next_addr  = slot_addr[nxt];
      rsp.released   = retired;
    end
    return rsp;
  endfunction

  // next expected result for one accepted request, updates the shadow table
  function automatic sched_rsp_t schedule_step(input sched_req_t req);
    sched_rsp_t rsp;
    bit         found;
    rsp   = '0;
    found = 1'b0;
    case (req.func)
      FUNC_CREATE: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!found && slot_st[i] == SLOT_UNUSED) begin
            slot_st[i]   = SLOT_READY;
            slot_addr[i] = req.entry_addr;
            rsp.slot     = SLOT_F_W'(i);
            found        = 1'b1;
          end
        end
        if (!found) rsp.status = STATUS_FULL;
      end
      FUNC_YIELD: begin
        rsp = switch_slot(req.resume_addr);
      end
      FUNC_EXIT: begin
        if (cur_slot % NUM_SLOTS != 0) slot_st[cur_slot % NUM_SLOTS] = SLOT_UNUSED;
        rsp = switch_slot(req.resume_addr);
      end
      default: begin
        rsp.slot = SLOT_F_W'(cur_slot);
      end
    endcase
    return rsp;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ADDR_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_req(input logic [FUNC_W-1:0] func, input logic [ADDR_W-1:0] entry,
                         input logic [ADDR_W-1:0] resume);
    sched_req_t req;
    req.func        = func;
    req.entry_addr  = entry;
    req.resume_addr = resume;
    req_q.push_back(req);
    req_total++;
  endtask

  // clock, reset, and known values on every input from time zero
  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.func     = FUNC_NONE;
    in_if.entry_addr  = '0;
    in_if.resume_addr = '0;
    out_if.ready   = 1'b0;
    repeat (8) #4 clk_i = ~clk_i;
    rst_ni = 1'b1;
    forever #4 clk_i = ~clk_i;
  end

  // shadow reset
  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_st[i]   = SLOT_UNUSED;
      slot_addr[i] = '0;
    end
    slot_st[0] = SLOT_RUNNING;
    cur_slot   = 0;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      gap_cnt     <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        rsp_q.push_back(schedule_step({in_if.func, in_if.entry_addr, in_if.resume_addr}));
        req_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_cnt != 0) begin
          gap_cnt     <= gap_cnt - 1;
          in_if.valid <= 1'b0;
        end else if (req_q.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
          gap_cnt     <= $urandom_range(0, 2);
          in_if.valid <= 1'b0;
        end else if (req_q.size() != 0) begin
          drv_req           = req_q.pop_front();
          in_if.valid       <= 1'b1;
          in_if.func        <= drv_req.func;
          in_if.entry_addr  <= drv_req.entry_addr;
          in_if.resume_addr <= drv_req.resume_addr;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_cnt    <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (rsp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN)
            $display("%0t: result with none expected: status %0d slot %0d addr %h rel %0d",
                     $realtime, out_if.status, out_if.slot, out_if.next_addr,
                     out_if.released);
        end else begin
          sched_rsp_t exp_rsp;
          exp_rsp = rsp_q.pop_front();
          if (out_if.status !== exp_rsp.status || out_if.slot !== exp_rsp.slot ||
              out_if.next_addr !== exp_rsp.next_addr ||
              out_if.released !== exp_rsp.released) begin
            err_cnt++;
            if (err_cnt <= MAX_SHOWN)
              $display("%0t: mismatch exp status %0d slot %0d addr %h rel %0d, got %0d %0d %h %0d",
                       $realtime, exp_rsp.status, exp_rsp.slot, exp_rsp.next_addr,
                       exp_rsp.released, out_if.status, out_if.slot, out_if.next_addr,
                       out_if.released);
          end
        end
      end
      if (stall_cnt != 0) begin
        stall_cnt    <= stall_cnt - 1;
        out_if.ready <= 1'b0;
      end else if (req_q.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
        stall_cnt    <= $urandom_range(0, 2);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int made;
    int mode;
    int pick;
    logic [FUNC_W-1:0] op;
    req_total = 0;
    req_taken = 0;
    err_cnt   = 0;

    // directed: empty table, full table, retire and reclaim, exit from slot 0
    add_req(FUNC_YIELD,  '0,        '0);
    add_req(FUNC_EXIT,   ADDR_ONES, ADDR_ONES);
    add_req(FUNC_NONE,   ADDR_ONES, ADDR_ONES);
    add_req(FUNC_CREATE, '0,        ADDR_ONES);
    add_req(FUNC_CREATE, ADDR_ONES, '0);
    add_req(FUNC_CREATE, 64'hA5A5_5A5A_0F0F_F0F0, '0);
    add_req(FUNC_CREATE, 64'h1234_5678_9ABC_DEF0, '0);
    add_req(FUNC_YIELD,  '0,        ADDR_ONES);
    add_req(FUNC_YIELD,  ADDR_ONES, '0);
    add_req(FUNC_EXIT,   '0,        64'h8000_0000_0000_0001);
    add_req(FUNC_CREATE, 64'h5555_AAAA_5555_AAAA, '0);
    add_req(FUNC_EXIT,   '0,        64'h0000_0000_FFFF_FFFF);
    add_req(FUNC_EXIT,   '0,        64'hFFFF_FFFF_0000_0000);
    add_req(FUNC_NONE,   '0,        '0);
    add_req(FUNC_EXIT,   '0,        64'hDEAD_BEEF_CAFE_F00D);
    add_req(FUNC_EXIT,   '0,        64'h0123_4567_89AB_CDEF);
    add_req(FUNC_YIELD,  '0,        64'h7FFF_FFFF_FFFF_FFFF);
    add_req(FUNC_CREATE, ADDR_ONES, '0);
    add_req(FUNC_YIELD,  '0,        ADDR_ONES);
    add_req(FUNC_YIELD,  '0,        '0);

    // random: operation mix shifts every 16 requests to fill and drain the table
    made = 0;
    mode = 0;
    while (made < RAND_ITEMS) begin
      if (made % 16 == 0) mode = $urandom_range(0, 2);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        op = FUNC_NONE;
      end else if (mode == 0) begin
        op = (pick < 60) ? FUNC_CREATE : (pick < 85) ? FUNC_YIELD : FUNC_EXIT;
      end else if (mode == 1) begin
        op = (pick < 35) ? FUNC_CREATE : (pick < 70) ? FUNC_YIELD : FUNC_EXIT;
      end else begin
        op = (pick < 20) ? FUNC_CREATE : (pick < 50) ? FUNC_YIELD : FUNC_EXIT;
      end
      add_req(op, rand_addr(), rand_addr());
      made++;
    end

    while (req_taken < req_total) @(posedge clk_i);
    while (rsp_q.size() != 0) @(posedge clk_i);
    repeat (2 * NUM_SLOTS + 8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== round_robin_thread_slot_scheduler.f =====
rtl/core/rrts_pkg.sv
rtl/core/rrts_in_if.sv
rtl/core/rrts_out_if.sv
rtl/core/rrts_ctrl.sv
rtl/core/rrts_dp.sv
rtl/core/round_robin_thread_slot_scheduler.sv
dv/tb.sv
